@@ rtl/core/rtcri_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rtcri_pkg;

  // item kinds carried on the request channel
  typedef enum logic [1:0] {
    ACT_READ       = 2'd0,
    ACT_WRITE      = 2'd1,
    ACT_TICK_HUND  = 2'd2,
    ACT_TICK_TENTH = 2'd3
  } action_t;

  localparam int unsigned ShiftW = 3;
  localparam int unsigned AddrW  = 12;
  localparam int unsigned IdxW   = 5;

  // register indexes
  localparam logic [IdxW-1:0] IDX_DOW = 5'd7;
  localparam logic [IdxW-1:0] IDX_INT = 5'd16;
  localparam logic [IdxW-1:0] IDX_CMD = 5'd17;

  // interrupt and command bits
  localparam int unsigned INT_PEND_BIT  = 7;
  localparam int unsigned INT_TENTH_BIT = 2;
  localparam int unsigned INT_HUND_BIT  = 1;
  localparam logic [7:0]  INT_BAD_BITS  = 8'h79;
  localparam int unsigned CMD_TEST_BIT  = 5;
  localparam int unsigned CMD_INTENA_BIT = 4;
  localparam int unsigned CMD_RUN_BIT   = 3;
  localparam logic [7:0]  UNDEF_READ    = 8'hff;

  typedef struct packed {
    action_t          action;
    logic [AddrW-1:0] bus_address;
    logic [7:0]       write_data;
    logic [6:0]       now_centisec;
    logic [4:0]       now_hour;
    logic [5:0]       now_minute;
    logic [5:0]       now_second;
    logic [3:0]       now_month;
    logic [4:0]       now_day;
    logic [7:0]       now_year;
    logic [2:0]       now_weekday;
  } req_t;

  // handshake between the input register and the core
  typedef struct packed {
    logic valid;
    req_t item;
  } stage_t;

endpackage

`default_nettype wire

@@ rtl/core/rtcri_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface rtcri_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [11:0] bus_address;
  logic [7:0] write_data;
  logic [6:0] now_centisec;
  logic [4:0] now_hour;
  logic [5:0] now_minute;
  logic [5:0] now_second;
  logic [3:0] now_month;
  logic [4:0] now_day;
  logic [7:0] now_year;
  logic [2:0] now_weekday;

  modport source (
    output valid, action, bus_address, write_data, now_centisec, now_hour,
           now_minute, now_second, now_month, now_day, now_year, now_weekday,
    input  ready
  );
  modport sink (
    input  valid, action, bus_address, write_data, now_centisec, now_hour,
           now_minute, now_second, now_month, now_day, now_year, now_weekday,
    output ready
  );
endinterface

interface rtcri_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq;
  logic       unsupported_write;

  modport source (output valid, read_data, irq, unsupported_write, input ready);
  modport sink (input valid, read_data, irq, unsupported_write, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rtcri_in_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rtcri_in_reg (
  input  wire logic            clk,
  input  wire logic            rst,
  rtcri_req_if.sink            req,
  output rtcri_pkg::stage_t    stage,
  input  wire logic            stage_ready
);
  import rtcri_pkg::*;

  logic valid;
  req_t item;
  logic load;

  assign req.ready = !valid || stage_ready;
  assign load      = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (stage_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item.action       <= action_t'(req.action);
      item.bus_address  <= req.bus_address;
      item.write_data   <= req.write_data;
      item.now_centisec <= req.now_centisec;
      item.now_hour     <= req.now_hour;
      item.now_minute   <= req.now_minute;
      item.now_second   <= req.now_second;
      item.now_month    <= req.now_month;
      item.now_day      <= req.now_day;
      item.now_year     <= req.now_year;
      item.now_weekday  <= req.now_weekday;
    end
  end

  assign stage.valid = valid;
  assign stage.item  = item;

endmodule

`default_nettype wire

@@ rtl/core/rtcri_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rtcri_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [rtcri_pkg::ShiftW-1:0] address_shift,
  input  rtcri_pkg::stage_t                stage,
  output logic                             stage_ready,
  rtcri_rsp_if.source                      rsp
);
  import rtcri_pkg::*;

  logic [7:0]       regs [16];
  logic [7:0]       status;
  logic [6:0]       mask;
  logic [7:0]       command;

  logic [7:0]       status_next;
  logic [6:0]       mask_next;
  logic [7:0]       command_next;

  logic [AddrW-1:0] shifted;
  logic [IdxW-1:0]  idx;
  logic             fire;
  logic             is_read;
  logic             is_write;
  logic             capture;
  logic [7:0]       cap [8];
  logic [7:0]       rd;
  logic             bad;
  logic             irq_next;

  logic             out_valid;
  logic [7:0]       out_data;
  logic             out_irq;
  logic             out_bad;

  assign stage_ready = !out_valid || rsp.ready;
  assign fire        = stage.valid && stage_ready;

  assign shifted  = stage.item.bus_address >> address_shift;
  assign idx      = shifted[IdxW-1:0];
  assign is_read  = (stage.item.action == ACT_READ);
  assign is_write = (stage.item.action == ACT_WRITE);
  assign capture  = (is_read || is_write) &&
                    ((command[CMD_RUN_BIT] && idx <= IDX_DOW) ||
                     (is_write && idx == IDX_CMD));

  // time bytes as they land in registers 0-7
  always_comb begin
    cap[0] = {1'b0, stage.item.now_centisec};
    cap[1] = {3'b0, stage.item.now_hour};
    cap[2] = {2'b0, stage.item.now_minute};
    cap[3] = {2'b0, stage.item.now_second};
    cap[4] = {4'b0, stage.item.now_month};
    cap[5] = {3'b0, stage.item.now_day};
    cap[6] = stage.item.now_year;
    cap[7] = {5'b0, stage.item.now_weekday};
  end

  always_comb begin
    rd           = 8'h00;
    bad          = 1'b0;
    status_next  = status;
    mask_next    = mask;
    command_next = command;
    case (stage.item.action)
      ACT_READ: begin
        if (!idx[4]) begin
          rd = (capture && !idx[3]) ? cap[idx[2:0]] : regs[idx[3:0]];
        end else if (idx == IDX_INT) begin
          rd          = status;
          status_next = 8'h00;
        end else begin
          rd = UNDEF_READ;
        end
      end
      ACT_WRITE: begin
        if (idx == IDX_INT) begin
          if ((stage.item.write_data & INT_BAD_BITS) != 8'h00) begin
            bad = 1'b1;
          end else begin
            mask_next = stage.item.write_data[6:0];
          end
        end else if (idx == IDX_CMD) begin
          if (stage.item.write_data[CMD_TEST_BIT]) begin
            bad = 1'b1;
          end else begin
            command_next = stage.item.write_data;
          end
        end
      end
      ACT_TICK_HUND: begin
        if (mask[INT_HUND_BIT]) begin
          status_next[INT_HUND_BIT] = 1'b1;
        end
      end
      default: begin
        if (!mask[INT_HUND_BIT] && mask[INT_TENTH_BIT]) begin
          status_next[INT_TENTH_BIT] = 1'b1;
        end
      end
    endcase
    if ((status_next[6:0] & mask_next) != 7'h00) begin
      status_next[INT_PEND_BIT] = 1'b1;
    end
    irq_next = ((status_next[6:0] & mask_next) != 7'h00) && command_next[CMD_INTENA_BIT];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        regs[i] <= 8'h00;
      end
      status  <= 8'h00;
      mask    <= 7'h00;
      command <= 8'h00;
    end else if (fire) begin
      // a direct write overrides the captured byte
      for (int i = 0; i < 8; i++) begin
        if (is_write && idx == IdxW'(i)) begin
          regs[i] <= stage.item.write_data;
        end else if (capture) begin
          regs[i] <= cap[i];
        end
      end
      for (int i = 8; i < 16; i++) begin
        if (is_write && idx == IdxW'(i)) begin
          regs[i] <= stage.item.write_data;
        end
      end
      status  <= status_next;
      mask    <= mask_next;
      command <= command_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= rd;
      out_irq  <= irq_next;
      out_bad  <= bad;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.read_data         = out_data;
  assign rsp.irq               = out_irq;
  assign rsp.unsupported_write = out_bad;

endmodule

`default_nettype wire

@@ rtl/core/rtc_register_interrupt_block_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// register face of a real-time clock with periodic interrupts
// req channel: one request per item (read, write, hundredth tick or
//   tenth tick) with the bus address, write byte and the current time
// rsp channel: one response per request, in order: read byte (zero for
//   writes and ticks), interrupt line level after the request, and a flag
//   for a write dropped because it set unsupported interrupt or test bits
// cfg port: cfg_we/cfg_wdata load the address shift; write it only while
//   no request is in flight
// path: a taken request is loaded into the input register, then passes once
//   through the register-file logic into the response register (rsp.valid)
// throughput: one request per cycle while rsp.ready is high; the register
//   read-modify-write is a single pass, so back-to-back requests never wait
//   on each other
// stall: while rsp.ready is low the response register holds and the input
//   register still takes one more request; req.ready drops only when both
//   are full
// reset: rst (synchronous) clears all registers, mask, status, command and
//   the address shift, and empties both pipeline registers
module rtc_register_interrupt_block_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  rtcri_req_if.sink                        req,
  rtcri_rsp_if.source                      rsp,
  input  wire logic                        cfg_we,
  input  wire logic [rtcri_pkg::ShiftW-1:0] cfg_wdata
);
  import rtcri_pkg::*;

  logic [ShiftW-1:0] address_shift;
  stage_t            stage;
  logic              stage_ready;

  // address shift register
  always_ff @(posedge clk) begin
    if (rst) begin
      address_shift <= '0;
    end else if (cfg_we) begin
      address_shift <= cfg_wdata;
    end
  end

  // input register, decoupled from the response side
  rtcri_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .stage       (stage),
    .stage_ready (stage_ready)
  );

  // register file, interrupt logic and response register
  rtcri_core u_core (
    .clk           (clk),
    .rst           (rst),
    .address_shift (address_shift),
    .stage         (stage),
    .stage_ready   (stage_ready),
    .rsp           (rsp)
  );

`ifndef SYNTHESIS
  // a response cannot appear right out of reset
  a_no_rsp_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !rsp.valid)
    else $error("response valid right after reset");

  // a dropped write never returns read data
  a_bad_has_no_data: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.unsupported_write |-> rsp.read_data == 8'h00)
    else $error("unsupported write returned read data");

  // a held request in the input register is not lost while the core stalls
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    stage.valid && !stage_ready |=> stage.valid && $stable(stage.item))
    else $error("input register lost a request under stall");
`endif

endmodule

`default_nettype wire

@@ tb/rtc_register_interrupt_block_top_test.sv @@
`timescale 1ns / 1ps

module rtc_register_interrupt_block_top_test;
  import rtcri_pkg::*;

  // register indexes used by the stimulus
  localparam logic [IdxW-1:0] REG_CENTISEC    = 5'd0;
  localparam logic [IdxW-1:0] REG_SECOND      = 5'd3;
  localparam logic [IdxW-1:0] REG_YEAR        = 5'd6;
  localparam logic [IdxW-1:0] REG_CMP_FIRST   = 5'd8;
  localparam logic [IdxW-1:0] REG_CMP_LAST    = 5'd15;
  localparam logic [IdxW-1:0] REG_UNDEF_FIRST = 5'd18;
  localparam logic [IdxW-1:0] REG_UNDEF_LAST  = 5'd31;

  // single-bit masks built from the package bit positions
  localparam logic [7:0] CMD_RUN    = 8'(1 << CMD_RUN_BIT);
  localparam logic [7:0] CMD_INTENA = 8'(1 << CMD_INTENA_BIT);
  localparam logic [7:0] CMD_TEST   = 8'(1 << CMD_TEST_BIT);
  localparam logic [7:0] INT_HUND   = 8'(1 << INT_HUND_BIT);
  localparam logic [7:0] INT_TENTH  = 8'(1 << INT_TENTH_BIT);
  localparam logic [7:0] INT_PEND   = 8'(1 << INT_PEND_BIT);

  localparam int RANDOM_PER_PHASE = 84;
  localparam int PHASES           = 6;
  localparam int LONG_STALL       = 60;
  localparam int QUIET_LIMIT      = 1000;

  // how the calendar fields of a request are filled
  typedef enum int {TIME_RANDOM, TIME_LOW, TIME_HIGH} time_span_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic       unsupported_write;
  } response_t;

  // shadow copy of the register file; predicts one response per request
  class rtc_register_shadow;
    logic [7:0] regs [16];
    logic [7:0] status;
    logic [6:0] mask;
    logic [7:0] command;
    logic [2:0] shift;
    response_t  expected_responses[$];
    int         mismatches;
    int         reads, writes, ticks, irq_high, dropped;

    function new();
      foreach (regs[i]) regs[i] = 8'h00;
      status = 8'h00;
      mask = 7'h00;
      command = 8'h00;
      shift = 3'd0;
      mismatches = 0;
      reads = 0;
      writes = 0;
      ticks = 0;
      irq_high = 0;
      dropped = 0;
    endfunction

    function void set_shift(logic [2:0] value);
      shift = value;
    endfunction

    function int pending();
      return expected_responses.size();
    endfunction

    function void note_request(req_t r);
      logic [11:0] shifted;
      logic [4:0]  idx;
      response_t   rsp;
      logic        is_write;
      shifted = r.bus_address >> shift;
      idx = shifted[4:0];
      rsp = '0;
      is_write = (r.action == ACT_WRITE);
      if (r.action == ACT_READ || r.action == ACT_WRITE) begin
        if ((command[CMD_RUN_BIT] && idx <= IDX_DOW) || (is_write && idx == IDX_CMD)) begin
          regs[0] = {1'b0, r.now_centisec};
          regs[1] = {3'b0, r.now_hour};
          regs[2] = {2'b0, r.now_minute};
          regs[3] = {2'b0, r.now_second};
          regs[4] = {4'b0, r.now_month};
          regs[5] = {3'b0, r.now_day};
          regs[6] = r.now_year;
          regs[7] = {5'b0, r.now_weekday};
        end
        if (is_write) begin
          writes++;
          if (idx <= REG_CMP_LAST) begin
            regs[idx[3:0]] = r.write_data;
          end else if (idx == IDX_INT) begin
            if ((r.write_data & INT_BAD_BITS) != 8'h00) rsp.unsupported_write = 1'b1;
            else mask = r.write_data[6:0];
          end else if (idx == IDX_CMD) begin
            if (r.write_data[CMD_TEST_BIT]) rsp.unsupported_write = 1'b1;
            else command = r.write_data;
          end
        end else begin
          reads++;
          if (idx <= REG_CMP_LAST) begin
            rsp.read_data = regs[idx[3:0]];
          end else if (idx == IDX_INT) begin
            rsp.read_data = status;
            status = 8'h00;
          end else begin
            rsp.read_data = UNDEF_READ;
          end
        end
      end else if (r.action == ACT_TICK_HUND) begin
        ticks++;
        if (mask[INT_HUND_BIT]) status[INT_HUND_BIT] = 1'b1;
      end else begin
        ticks++;
        if (!mask[INT_HUND_BIT] && mask[INT_TENTH_BIT]) status[INT_TENTH_BIT] = 1'b1;
      end
      if ((status & {1'b0, mask}) != 8'h00) status[INT_PEND_BIT] = 1'b1;
      rsp.irq = ((status & {1'b0, mask}) != 8'h00) && command[CMD_INTENA_BIT];
      if (rsp.irq) irq_high++;
      if (rsp.unsupported_write) dropped++;
      expected_responses.push_back(rsp);
    endfunction

    function void check_response(logic [7:0] read_data, logic irq, logic unsupported_write);
      response_t e;
      if (expected_responses.size() == 0) begin
        $error("response with no request outstanding");
        mismatches++;
        return;
      end
      e = expected_responses.pop_front();
      if (read_data !== e.read_data) begin
        $error("read_data: expected %h, got %h", e.read_data, read_data);
        mismatches++;
      end
      if (irq !== e.irq) begin
        $error("irq: expected %b, got %b", e.irq, irq);
        mismatches++;
      end
      if (unsupported_write !== e.unsupported_write) begin
        $error("unsupported_write: expected %b, got %b", e.unsupported_write,
               unsupported_write);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [2:0] cfg_wdata;

  rtcri_req_if req_bus ();
  rtcri_rsp_if rsp_bus ();

  rtc_register_interrupt_block_top dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_bus),
    .rsp       (rsp_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  rtc_register_shadow shadow = new();
  logic [2:0] cur_shift = 3'd0;
  bit         long_stall_req = 1'b0;
  int         quiet_cycles = 0;
  int         shifts_used = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // request generation
  // ---------------------------------------------------------------------

  // place idx at the shifted position, random junk in all other bits
  function automatic logic [11:0] address_of(logic [4:0] idx, logic [2:0] sh);
    logic [11:0] keep;
    keep = 12'h01f << sh;
    return (12'($urandom) & ~keep) | (12'(idx) << sh);
  endfunction

  function automatic req_t with_time(req_t r, time_span_t span);
    case (span)
      TIME_LOW: begin
        r.now_centisec = 7'd0;
        r.now_hour = 5'd0;
        r.now_minute = 6'd0;
        r.now_second = 6'd0;
        r.now_month = 4'd1;
        r.now_day = 5'd1;
        r.now_year = 8'd0;
        r.now_weekday = 3'd0;
      end
      TIME_HIGH: begin
        r.now_centisec = 7'd99;
        r.now_hour = 5'd23;
        r.now_minute = 6'd59;
        r.now_second = 6'd60;
        r.now_month = 4'd12;
        r.now_day = 5'd31;
        r.now_year = 8'd255;
        r.now_weekday = 3'd6;
      end
      default: begin
        r.now_centisec = 7'($urandom_range(0, 99));
        r.now_hour = 5'($urandom_range(0, 23));
        r.now_minute = 6'($urandom_range(0, 59));
        r.now_second = 6'($urandom_range(0, 60));
        r.now_month = 4'($urandom_range(1, 12));
        r.now_day = 5'($urandom_range(1, 31));
        r.now_year = 8'($urandom_range(0, 255));
        r.now_weekday = 3'($urandom_range(0, 6));
      end
    endcase
    return r;
  endfunction

  function automatic req_t make_request(action_t a, logic [4:0] idx, logic [7:0] data,
                                        time_span_t span);
    req_t r;
    r = '0;
    r.action = a;
    r.bus_address = address_of(idx, cur_shift);
    r.write_data = data;
    return with_time(r, span);
  endfunction

  // time registers get the most traffic, compare and undefined registers the least
  function automatic logic [4:0] pick_index();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return 5'($urandom_range(REG_CENTISEC, IDX_DOW));
    if (pick < 45) return 5'($urandom_range(REG_CMP_FIRST, REG_CMP_LAST));
    if (pick < 65) return IDX_INT;
    if (pick < 85) return IDX_CMD;
    return 5'($urandom_range(REG_UNDEF_FIRST, REG_UNDEF_LAST));
  endfunction

  // mostly legal mask and command bytes, with the odd unsupported one
  function automatic logic [7:0] pick_write_data(logic [4:0] idx);
    logic [7:0] data;
    data = 8'($urandom);
    if (idx == IDX_INT && $urandom_range(0, 9) < 8) begin
      data = data & (INT_PEND | INT_TENTH | INT_HUND);
    end else if (idx == IDX_CMD && $urandom_range(0, 9) < 8) begin
      data = data & ~CMD_TEST;
      if ($urandom_range(0, 1) == 1) data = data | CMD_RUN | CMD_INTENA;
    end
    return data;
  endfunction

  function automatic req_t random_request();
    req_t       r;
    int         pick;
    logic [4:0] idx;
    r = '0;
    pick = $urandom_range(0, 99);
    r.action = (pick < 35) ? ACT_READ :
               (pick < 70) ? ACT_WRITE :
               (pick < 85) ? ACT_TICK_HUND : ACT_TICK_TENTH;
    idx = pick_index();
    // now and then a fully random address, whatever index it lands on
    r.bus_address = ($urandom_range(0, 19) == 0) ? 12'($urandom) : address_of(idx, cur_shift);
    r.write_data = pick_write_data(idx);
    return with_time(r, TIME_RANDOM);
  endfunction

  // ---------------------------------------------------------------------
  // request side drivers
  // ---------------------------------------------------------------------

  // present one request and hold it until the block takes it
  task automatic drive_request(req_t r);
    req_bus.valid <= 1'b1;
    req_bus.action <= r.action;
    req_bus.bus_address <= r.bus_address;
    req_bus.write_data <= r.write_data;
    req_bus.now_centisec <= r.now_centisec;
    req_bus.now_hour <= r.now_hour;
    req_bus.now_minute <= r.now_minute;
    req_bus.now_second <= r.now_second;
    req_bus.now_month <= r.now_month;
    req_bus.now_day <= r.now_day;
    req_bus.now_year <= r.now_year;
    req_bus.now_weekday <= r.now_weekday;
    do @(posedge clk); while (!req_bus.ready);
    shadow.note_request(r);
  endtask

  task automatic pause_sender(int cycles);
    req_bus.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // stop offering and wait until every outstanding response came back
  task automatic drain();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (shadow.pending() != 0);
  endtask

  // only called while nothing is in flight
  task automatic write_shift(logic [2:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow.set_shift(value);
    cur_shift = value;
    shifts_used++;
  endtask

  // random requests in bursts of random length, random gaps before most bursts
  task automatic send_random(int count);
    int burst;
    burst = 0;
    repeat (count) begin
      if (burst == 0) begin
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
      end
      drive_request(random_request());
      burst--;
    end
  endtask

  // ---------------------------------------------------------------------
  // response side: stall pattern, long hold-off, checking
  // ---------------------------------------------------------------------

  // ready switches between always-on, mostly-on, mostly-off and toggling,
  // each for a random stretch; a long hold-off is taken when asked for
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        rsp_bus.ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(10, 50);
        end
        left--;
        case (mode)
          0: rsp_bus.ready <= 1'b1;
          1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
          2: rsp_bus.ready <= ($urandom_range(0, 2) == 0);
          default: rsp_bus.ready <= ~rsp_bus.ready;
        endcase
      end
    end
  end

  // every accepted response is compared with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_bus.valid && rsp_bus.ready)
      shadow.check_response(rsp_bus.read_data, rsp_bus.irq, rsp_bus.unsupported_write);
  end

  // a run that stops moving on both channels is a failure
  always @(posedge clk) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d quiet cycles, %0d responses outstanding",
                 quiet_cycles, shadow.pending());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    req_t r;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= 3'd0;
    req_bus.valid <= 1'b0;
    req_bus.action <= ACT_READ;
    req_bus.bus_address <= '0;
    req_bus.write_data <= '0;
    req_bus.now_centisec <= '0;
    req_bus.now_hour <= '0;
    req_bus.now_minute <= '0;
    req_bus.now_second <= '0;
    req_bus.now_month <= '0;
    req_bus.now_day <= '0;
    req_bus.now_year <= '0;
    req_bus.now_weekday <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_shift(3'd0);

    // directed: registers straight out of reset, lowest address
    r = make_request(ACT_READ, REG_CENTISEC, 8'h00, TIME_LOW);
    r.bus_address = 12'h000;
    drive_request(r);
    // command write captures the time even with run clear; largest time values
    drive_request(make_request(ACT_WRITE, IDX_CMD, CMD_RUN | CMD_INTENA, TIME_HIGH));
    // with run set a time register access captures first
    drive_request(make_request(ACT_READ, REG_CENTISEC, 8'h00, TIME_LOW));
    drive_request(make_request(ACT_READ, REG_YEAR, 8'h00, TIME_HIGH));
    // a write to a time register lands on top of the capture
    drive_request(make_request(ACT_WRITE, REG_SECOND, 8'hff, TIME_RANDOM));
    drive_request(make_request(ACT_READ, REG_SECOND, 8'h00, TIME_RANDOM));
    // compare registers are plain storage
    drive_request(make_request(ACT_WRITE, REG_CMP_FIRST, 8'hff, TIME_RANDOM));
    drive_request(make_request(ACT_READ, REG_CMP_FIRST, 8'h00, TIME_RANDOM));
    drive_request(make_request(ACT_WRITE, REG_CMP_LAST, 8'h00, TIME_RANDOM));
    drive_request(make_request(ACT_READ, REG_CMP_LAST, 8'h00, TIME_RANDOM));
    // tick with nothing unmasked does nothing
    drive_request(make_request(ACT_TICK_HUND, REG_CENTISEC, 8'h00, TIME_RANDOM));
    // hundredth interrupt: raises irq, hides the tenth tick, clears on read
    drive_request(make_request(ACT_WRITE, IDX_INT, INT_HUND, TIME_RANDOM));
    drive_request(make_request(ACT_TICK_HUND, REG_CENTISEC, 8'h00, TIME_RANDOM));
    drive_request(make_request(ACT_TICK_TENTH, REG_CENTISEC, 8'h00, TIME_RANDOM));
    drive_request(make_request(ACT_READ, IDX_INT, 8'h00, TIME_RANDOM));
    // tenth interrupt on its own
    drive_request(make_request(ACT_WRITE, IDX_INT, INT_TENTH, TIME_RANDOM));
    drive_request(make_request(ACT_TICK_TENTH, REG_CENTISEC, 8'h00, TIME_RANDOM));
    drive_request(make_request(ACT_READ, IDX_INT, 8'h00, TIME_RANDOM));
    // both unmasked: tenth tick is suppressed
    drive_request(make_request(ACT_WRITE, IDX_INT, INT_TENTH | INT_HUND, TIME_RANDOM));
    drive_request(make_request(ACT_TICK_TENTH, REG_CENTISEC, 8'h00, TIME_RANDOM));
    // unsupported interrupt bits dropped; pending bit in a write is accepted
    drive_request(make_request(ACT_WRITE, IDX_INT, ~INT_PEND, TIME_RANDOM));
    drive_request(make_request(ACT_WRITE, IDX_INT, INT_PEND, TIME_RANDOM));
    // test mode write dropped but still captures, command reads back as all ones
    drive_request(make_request(ACT_WRITE, IDX_CMD, CMD_TEST, TIME_HIGH));
    drive_request(make_request(ACT_READ, IDX_CMD, 8'h00, TIME_RANDOM));
    // undefined registers: write ignored, read all ones, highest address
    drive_request(make_request(ACT_WRITE, REG_UNDEF_LAST, 8'h5a, TIME_RANDOM));
    r = make_request(ACT_READ, REG_UNDEF_LAST, 8'h00, TIME_RANDOM);
    r.bus_address = 12'hfff;
    drive_request(r);
    // run off: no capture on a time register read
    drive_request(make_request(ACT_WRITE, IDX_CMD, 8'h00, TIME_RANDOM));
    drive_request(make_request(ACT_READ, REG_CENTISEC, 8'h00, TIME_LOW));

    // random phases, each under an address shift written before it; largest first
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: write_shift(3'd7);
        1: write_shift(3'd3);
        2: write_shift(3'd1);
        3: write_shift(3'd5);
        4: write_shift(3'd0);
        default: write_shift(3'($urandom_range(0, 7)));
      endcase
      if (phase == 1) begin
        // receiver holds off while requests keep coming, so both pipeline
        // registers fill and the request side backs up
        long_stall_req = 1'b1;
        repeat (16) drive_request(random_request());
      end
      send_random(RANDOM_PER_PHASE);
    end

    drain();
    repeat (4) @(posedge clk);
    $display("covered %0d reads, %0d writes, %0d ticks across %0d address shifts",
             shadow.reads, shadow.writes, shadow.ticks, shifts_used);
    $display("responses with irq high: %0d, dropped writes: %0d",
             shadow.irq_high, shadow.dropped);
    if (shadow.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ rtc_register_interrupt_block_top.f @@
rtl/core/rtcri_pkg.sv
rtl/core/rtcri_ifs.sv
rtl/core/rtcri_in_reg.sv
rtl/core/rtcri_core.sv
rtl/core/rtc_register_interrupt_block_top.sv
tb/rtc_register_interrupt_block_top_test.sv
